// ----- hdl/tjdm_pkg.sv -----
// Shared types and constants for the touch joystick drive mapper.
package tjdm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_INTERVAL = 3'd4;

  localparam logic [9:0]  CENTER_X_RST      = 10'd120;
  localparam logic [9:0]  CENTER_Y_RST      = 10'd120;
  localparam logic [8:0]  RADIUS_RST        = 9'd100;
  localparam logic [14:0] DEAD_ZONE_RST     = 15'd1638;
  localparam logic [15:0] SEND_INTERVAL_RST = 16'd50;

  localparam int NUM_LANES = 4;
  localparam int LANE_KX   = 0;
  localparam int LANE_KY   = 1;
  localparam int LANE_LIN  = 2;
  localparam int LANE_ANG  = 3;

  localparam logic [3:0] ITER_LAST = 4'd15;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_COMPARE,
    S_SQRT,
    S_PREP,
    S_DIV,
    S_FINISH
  } state_t;

endpackage

// ----- hdl/touch_joystick_drive_mapper.sv -----
// Touch joystick to differential drive mapper: clamp, normalize, dead zone, send pacing.
//
// One input transaction is one update tick and yields exactly one result transaction.
// A tick with a touch inside the joystick circle runs squares, compare, prep, a bit-serial
// divider for all four quotients and finish; a touch outside the circle adds a bit-serial
// square root after compare; a tick without a touch goes straight to finish. The square
// root and the four divider lanes each retire one result bit per cycle. The result sits in
// an output register, so a new tick is taken while the previous result is still stalled;
// the finish state waits only while that register is full and out_stall is high. The user
// must write configuration through cfg_we, cfg_index and cfg_data while no tick is in flight;
// the block itself does not enforce this. Unknown indexes are ignored.
module touch_joystick_drive_mapper #(
  parameter int FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tjdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tjdm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_touched,
  input  logic signed [15:0]            in_touch_x,
  input  logic signed [15:0]            in_touch_y,
  input  logic [31:0]                   in_now_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_send,
  output logic signed [15:0]            out_linear,
  output logic signed [15:0]            out_angular,
  output logic signed [15:0]            out_knob_x,
  output logic signed [15:0]            out_knob_y,
  output logic                          out_active
);
  import tjdm_pkg::*;

  localparam logic [15:0] OneVal = 16'(32'd1 << FRAC_BITS);

  state_t state_r, state_nxt;

  logic [9:0]  center_x_r, center_y_r;
  logic [8:0]  radius_r;
  logic [14:0] dead_zone_r;
  logic [15:0] send_interval_r;

  logic        held_r;
  logic [31:0] last_send_r;

  logic        touched_r;
  logic [31:0] now_r;
  logic [15:0] adx_r, ady_r;
  logic        sx_r, sy_r;
  logic [8:0]  r_r;
  logic [17:0] rr_r;
  logic [31:0] sqx_r, sqy_r;
  logic        clamp_r;
  logic [3:0]  cnt_r;

  logic [31:0] sq_val_r;
  logic [16:0] sq_rem_r;
  logic [15:0] sq_root_r;

  logic [15:0] den_r;
  logic [15:0] lane_rem_r [NUM_LANES];
  logic [15:0] lane_nq_r  [NUM_LANES];

  logic        out_valid_r;
  logic        out_send_r, out_active_r;
  logic [15:0] out_linear_r, out_angular_r, out_knob_x_r, out_knob_y_r;

  logic               in_fire, fin_fire;
  logic signed [16:0] dx_w, dy_w;
  logic [15:0]        adx_w, ady_w;
  logic [8:0]         r_eff_w;
  logic [32:0]        d2_w;
  logic [18:0]        sq_t_w, sq_trial_w;
  logic               sq_ge_w;
  logic [24:0]        kx_prod_w, ky_prod_w;
  logic [31:0]        lin_num_w, ang_num_w;
  logic [16:0]        lane_t_w  [NUM_LANES];
  logic               lane_ge_w [NUM_LANES];
  logic [15:0]        lin_mag_w, ang_mag_w, koff_x_w, koff_y_w;
  logic [31:0]        elapsed_w;
  logic               pace_ok_w;

  function automatic logic [15:0] shape_mag(input logic [15:0] mag, input logic [14:0] dz,
                                            input logic [15:0] one);
    logic [15:0] res;
    res = mag;
    if (mag < {1'b0, dz}) begin
      res = '0;
    end else if (mag > one) begin
      res = one;
    end
    return res;
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign fin_fire  = (state_r == S_FINISH) && (!out_valid_r || !out_stall);

  assign dx_w    = {in_touch_x[15], in_touch_x} - $signed({7'd0, center_x_r});
  assign dy_w    = {in_touch_y[15], in_touch_y} - $signed({7'd0, center_y_r});
  assign adx_w   = dx_w[16] ? 16'(-dx_w) : dx_w[15:0];
  assign ady_w   = dy_w[16] ? 16'(-dy_w) : dy_w[15:0];
  assign r_eff_w = (radius_r == '0) ? 9'd1 : radius_r;

  assign d2_w = {1'b0, sqx_r} + {1'b0, sqy_r};

  assign sq_t_w     = {sq_rem_r, sq_val_r[31:30]};
  assign sq_trial_w = {1'b0, sq_root_r, 2'b01};
  assign sq_ge_w    = (sq_t_w >= sq_trial_w);

  assign kx_prod_w = {9'd0, adx_r} * {16'd0, r_r};
  assign ky_prod_w = {9'd0, ady_r} * {16'd0, r_r};
  assign lin_num_w = {16'd0, ady_r} << FRAC_BITS;
  assign ang_num_w = {16'd0, adx_r} << FRAC_BITS;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_t_w[i]  = {lane_rem_r[i], lane_nq_r[i][15]};
      lane_ge_w[i] = (lane_t_w[i] >= {1'b0, den_r});
    end
  end

  assign lin_mag_w = shape_mag(lane_nq_r[LANE_LIN], dead_zone_r, OneVal);
  assign ang_mag_w = shape_mag(lane_nq_r[LANE_ANG], dead_zone_r, OneVal);
  assign koff_x_w  = clamp_r ? lane_nq_r[LANE_KX] : adx_r;
  assign koff_y_w  = clamp_r ? lane_nq_r[LANE_KY] : ady_r;
  assign elapsed_w = now_r - last_send_r;
  assign pace_ok_w = (elapsed_w >= {16'd0, send_interval_r});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = in_touched ? S_SQUARE : S_FINISH;
        end
      end
      S_SQUARE:  state_nxt = S_COMPARE;
      S_COMPARE: state_nxt = (d2_w > {15'd0, rr_r}) ? S_SQRT : S_PREP;
      S_SQRT: begin
        if (cnt_r == ITER_LAST) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: state_nxt = S_DIV;
      S_DIV: begin
        if (cnt_r == ITER_LAST) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (fin_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      held_r          <= 1'b0;
      last_send_r     <= '0;
      center_x_r      <= CENTER_X_RST;
      center_y_r      <= CENTER_Y_RST;
      radius_r        <= RADIUS_RST;
      dead_zone_r     <= DEAD_ZONE_RST;
      send_interval_r <= SEND_INTERVAL_RST;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CENTER_X:      center_x_r      <= cfg_data[9:0];
          CFG_CENTER_Y:      center_y_r      <= cfg_data[9:0];
          CFG_RADIUS:        radius_r        <= cfg_data[8:0];
          CFG_DEAD_ZONE:     dead_zone_r     <= cfg_data[14:0];
          CFG_SEND_INTERVAL: send_interval_r <= cfg_data;
          default: ;
        endcase
      end

      if (in_fire) begin
        touched_r <= in_touched;
        now_r     <= in_now_ms;
        adx_r     <= adx_w;
        ady_r     <= ady_w;
        sx_r      <= dx_w[16];
        sy_r      <= dy_w[16];
        r_r       <= r_eff_w;
        rr_r      <= {9'd0, r_eff_w} * {9'd0, r_eff_w};
      end

      if (state_r == S_SQUARE) begin
        sqx_r <= {16'd0, adx_r} * {16'd0, adx_r};
        sqy_r <= {16'd0, ady_r} * {16'd0, ady_r};
      end

      if (state_r == S_COMPARE) begin
        clamp_r   <= (d2_w > {15'd0, rr_r});
        sq_val_r  <= d2_w[31:0];
        sq_rem_r  <= '0;
        sq_root_r <= '0;
        cnt_r     <= '0;
      end

      if (state_r == S_SQRT) begin
        sq_rem_r  <= sq_ge_w ? 17'(sq_t_w - sq_trial_w) : sq_t_w[16:0];
        sq_root_r <= {sq_root_r[14:0], sq_ge_w};
        sq_val_r  <= {sq_val_r[29:0], 2'b00};
        cnt_r     <= cnt_r + 4'd1;
      end

      if (state_r == S_PREP) begin
        den_r                <= clamp_r ? sq_root_r : {7'd0, r_r};
        lane_rem_r[LANE_KX]  <= {7'd0, kx_prod_w[24:16]};
        lane_nq_r[LANE_KX]   <= kx_prod_w[15:0];
        lane_rem_r[LANE_KY]  <= {7'd0, ky_prod_w[24:16]};
        lane_nq_r[LANE_KY]   <= ky_prod_w[15:0];
        lane_rem_r[LANE_LIN] <= lin_num_w[31:16];
        lane_nq_r[LANE_LIN]  <= lin_num_w[15:0];
        lane_rem_r[LANE_ANG] <= ang_num_w[31:16];
        lane_nq_r[LANE_ANG]  <= ang_num_w[15:0];
        cnt_r                <= '0;
      end

      if (state_r == S_DIV) begin
        for (int i = 0; i < NUM_LANES; i++) begin
          lane_rem_r[i] <= lane_ge_w[i] ? 16'(lane_t_w[i] - {1'b0, den_r})
                                        : lane_t_w[i][15:0];
          lane_nq_r[i]  <= {lane_nq_r[i][14:0], lane_ge_w[i]};
        end
        cnt_r <= cnt_r + 4'd1;
      end

      if (fin_fire) begin
        out_valid_r <= 1'b1;
        if (touched_r) begin
          held_r        <= 1'b1;
          out_active_r  <= 1'b1;
          out_send_r    <= pace_ok_w;
          out_linear_r  <= sy_r ? lin_mag_w : 16'(16'd0 - lin_mag_w);
          out_angular_r <= sx_r ? 16'(16'd0 - ang_mag_w) : ang_mag_w;
          out_knob_x_r  <= 16'({6'd0, center_x_r} + (sx_r ? 16'(16'd0 - koff_x_w) : koff_x_w));
          out_knob_y_r  <= 16'({6'd0, center_y_r} + (sy_r ? 16'(16'd0 - koff_y_w) : koff_y_w));
          if (pace_ok_w) begin
            last_send_r <= now_r;
          end
        end else begin
          held_r        <= 1'b0;
          out_active_r  <= 1'b0;
          out_send_r    <= held_r;
          out_linear_r  <= '0;
          out_angular_r <= '0;
          out_knob_x_r  <= {6'd0, center_x_r};
          out_knob_y_r  <= {6'd0, center_y_r};
          if (held_r) begin
            last_send_r <= now_r;
          end
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_send    = out_send_r;
  assign out_linear  = out_linear_r;
  assign out_angular = out_angular_r;
  assign out_knob_x  = out_knob_x_r;
  assign out_knob_y  = out_knob_y_r;
  assign out_active  = out_active_r;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_stall)
    else $error("tick accepted but block did not go busy");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (lane_rem_r[LANE_KX] < den_r) && (lane_rem_r[LANE_KY] < den_r)
      && (lane_rem_r[LANE_LIN] < den_r) && (lane_rem_r[LANE_ANG] < den_r))
    else $error("divider remainder not below divisor");

  a_cmd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && touched_r) |->
      (lane_nq_r[LANE_LIN] <= OneVal) && (lane_nq_r[LANE_ANG] <= OneVal))
    else $error("command quotient above full scale");
`endif

endmodule
